// ===== rtl/psc_pkg.sv =====
// ---------------------------------------------------------------------------
// Pressure sensor compensation package
// Shared widths, calibration register indexes and the calibration word bundle.
// ---------------------------------------------------------------------------
package psc_pkg;

	localparam int ADC_W  = 24;
	localparam int CAL_W  = 16;
	localparam int IDX_W  = 3;
	localparam int TEMP_W = 19;
	localparam int PRES_W = 25;

	// Intermediate widths of the datapath.
	localparam int DT_W   = 25;
	localparam int PROD_W = 42;
	localparam int OFF_W  = 36;
	localparam int SENS_W = 35;

	localparam logic [IDX_W-1:0] CAL_IDX_C1 = 3'd0;
	localparam logic [IDX_W-1:0] CAL_IDX_C2 = 3'd1;
	localparam logic [IDX_W-1:0] CAL_IDX_C3 = 3'd2;
	localparam logic [IDX_W-1:0] CAL_IDX_C4 = 3'd3;
	localparam logic [IDX_W-1:0] CAL_IDX_C5 = 3'd4;
	localparam logic [IDX_W-1:0] CAL_IDX_C6 = 3'd5;

	localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

	typedef struct packed {
		logic [CAL_W-1:0] c1;
		logic [CAL_W-1:0] c2;
		logic [CAL_W-1:0] c3;
		logic [CAL_W-1:0] c4;
		logic [CAL_W-1:0] c5;
		logic [CAL_W-1:0] c6;
	} psc_cal_t;

endpackage

// ===== rtl/psc_smp_if.sv =====
// ---------------------------------------------------------------------------
// Sample channel
// Carries one pair of raw pressure and temperature conversions per request.
// ---------------------------------------------------------------------------
interface psc_smp_if;
	import psc_pkg::*;

	logic             valid;
	logic             ready;
	logic [ADC_W-1:0] pressure_adc;
	logic [ADC_W-1:0] temperature_adc;

	modport source (output valid, output pressure_adc, output temperature_adc, input ready);
	modport sink (input valid, input pressure_adc, input temperature_adc, output ready);

endinterface

// ===== rtl/psc_res_if.sv =====
// ---------------------------------------------------------------------------
// Result channel
// Carries compensated temperature and pressure, one pair per request.
// ---------------------------------------------------------------------------
interface psc_res_if;
	import psc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic signed [PRES_W-1:0] pressure_comp;

	modport source (output valid, output temperature_centi, output pressure_comp, input ready);
	modport sink (input valid, input temperature_centi, input pressure_comp, output ready);

endinterface

// ===== rtl/psc_cal_regs.sv =====
// ---------------------------------------------------------------------------
// Calibration register file
// Holds the six factory calibration words written through the config port.
// ---------------------------------------------------------------------------
module psc_cal_regs
	import psc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0] cfg_data,
	output psc_cal_t         cal
);

	psc_cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CAL_IDX_C1: begin
					cal_q.c1 <= cfg_data;
				end
				CAL_IDX_C2: begin
					cal_q.c2 <= cfg_data;
				end
				CAL_IDX_C3: begin
					cal_q.c3 <= cfg_data;
				end
				CAL_IDX_C4: begin
					cal_q.c4 <= cfg_data;
				end
				CAL_IDX_C5: begin
					cal_q.c5 <= cfg_data;
				end
				CAL_IDX_C6: begin
					cal_q.c6 <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cal = cal_q;

endmodule

// ===== rtl/psc_front.sv =====
// ---------------------------------------------------------------------------
// Temperature and coefficient stages
// Three stages: temperature difference, the three calibration products, and
// the compensated temperature with the pressure offset and sensitivity.
// ---------------------------------------------------------------------------
module psc_front
	import psc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  psc_cal_t                 cal,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [ADC_W-1:0]         pressure_adc,
	input  logic [ADC_W-1:0]         temperature_adc,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ADC_W-1:0]         d1,
	output logic signed [TEMP_W-1:0] temp,
	output logic signed [OFF_W-1:0]  off,
	output logic signed [SENS_W-1:0] sens
);

	logic valid_s1, valid_s2, valid_s3;
	logic adv_s1, adv_s2, adv_s3;

	logic [ADC_W-1:0]         d1_s1, d1_s2, d1_s3;
	logic signed [DT_W-1:0]   dt_s1;
	logic signed [PROD_W-1:0] p6_s2, p4_s2, p3_s2;
	logic signed [TEMP_W-1:0] temp_s3;
	logic signed [OFF_W-1:0]  off_s3;
	logic signed [SENS_W-1:0] sens_s3;

	logic signed [DT_W-1:0]   dt_c;
	logic signed [PROD_W-1:0] t_adj;
	logic signed [TEMP_W-1:0] temp_c;
	logic signed [OFF_W-1:0]  off_c;
	logic signed [SENS_W-1:0] sens_c;

	assign adv_s3   = !valid_s3 || out_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	assign dt_c = $signed({1'b0, temperature_adc}) - $signed({1'b0, cal.c5, 8'h00});

	// Truncation toward zero of the temperature term needs a bias on negative values.
	always_comb begin
		t_adj  = p6_s2 + (p6_s2[PROD_W-1] ? 42'sd8388607 : 42'sd0);
		temp_c = TEMP_BASE + $signed(t_adj[PROD_W-1:23]);
		off_c  = $signed({3'b000, cal.c2, 17'h00000}) + $signed(p4_s2[PROD_W-1:6]);
		sens_c = $signed({3'b000, cal.c1, 16'h0000}) + $signed(p3_s2[PROD_W-1:7]);
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			dt_s1 <= dt_c;
			d1_s1 <= pressure_adc;
		end
		if (adv_s2) begin
			p6_s2 <= dt_s1 * $signed({1'b0, cal.c6});
			p4_s2 <= dt_s1 * $signed({1'b0, cal.c4});
			p3_s2 <= dt_s1 * $signed({1'b0, cal.c3});
			d1_s2 <= d1_s1;
		end
		if (adv_s3) begin
			temp_s3 <= temp_c;
			off_s3  <= off_c;
			sens_s3 <= sens_c;
			d1_s3   <= d1_s2;
		end
	end

	assign out_valid = valid_s3;
	assign d1        = d1_s3;
	assign temp      = temp_s3;
	assign off       = off_s3;
	assign sens      = sens_s3;

endmodule

// ===== rtl/psc_back.sv =====
// ---------------------------------------------------------------------------
// Pressure stages
// Five stages: split sensitivity products, their sum, the first truncating
// scale, the offset subtraction and the final truncating scale.
// ---------------------------------------------------------------------------
module psc_back
	import psc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [ADC_W-1:0]         d1,
	input  logic signed [TEMP_W-1:0] temp,
	input  logic signed [OFF_W-1:0]  off,
	input  logic signed [SENS_W-1:0] sens,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [TEMP_W-1:0] temperature_centi,
	output logic signed [PRES_W-1:0] pressure_comp
);

	localparam int LO_W   = 17;
	localparam int HI_W   = SENS_W - LO_W;
	localparam int PLO_W  = ADC_W + LO_W;
	localparam int PHI_W  = ADC_W + 1 + HI_W;
	localparam int SUM_W  = PHI_W + LO_W;
	localparam int Q_W    = SUM_W - 21;
	localparam int DIFF_W = Q_W + 1;

	logic valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic adv_s4, adv_s5, adv_s6, adv_s7, adv_s8;

	logic [PLO_W-1:0]          plo_s4;
	logic signed [PHI_W-1:0]   phi_s4;
	logic signed [SUM_W-1:0]   sum_s5;
	logic signed [Q_W-1:0]     q_s6;
	logic signed [DIFF_W-1:0]  diff_s7;
	logic signed [PRES_W-1:0]  pres_s8;
	logic signed [OFF_W-1:0]   off_s4, off_s5, off_s6;
	logic signed [TEMP_W-1:0]  temp_s4, temp_s5, temp_s6, temp_s7, temp_s8;

	logic signed [SUM_W-1:0]   sum_adj;
	logic signed [DIFF_W-1:0]  diff_adj;

	assign adv_s8   = !valid_s8 || out_ready;
	assign adv_s7   = !valid_s7 || adv_s8;
	assign adv_s6   = !valid_s6 || adv_s7;
	assign adv_s5   = !valid_s5 || adv_s6;
	assign adv_s4   = !valid_s4 || adv_s5;
	assign in_ready = adv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (adv_s4) begin
				valid_s4 <= in_valid;
			end
			if (adv_s5) begin
				valid_s5 <= valid_s4;
			end
			if (adv_s6) begin
				valid_s6 <= valid_s5;
			end
			if (adv_s7) begin
				valid_s7 <= valid_s6;
			end
			if (adv_s8) begin
				valid_s8 <= valid_s7;
			end
		end
	end

	// Both scales truncate toward zero, so negative values get a bias first.
	always_comb begin
		sum_adj  = sum_s5 + (sum_s5[SUM_W-1] ? $signed(SUM_W'(21'h1FFFFF)) : '0);
		diff_adj = diff_s7 + (diff_s7[DIFF_W-1] ? $signed(DIFF_W'(13'h1FFF)) : '0);
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			plo_s4  <= d1 * sens[LO_W-1:0];
			phi_s4  <= $signed({1'b0, d1}) * $signed(sens[SENS_W-1:LO_W]);
			off_s4  <= off;
			temp_s4 <= temp;
		end
		if (adv_s5) begin
			sum_s5  <= $signed({phi_s4, {LO_W{1'b0}}}) + $signed({{(SUM_W-PLO_W){1'b0}}, plo_s4});
			off_s5  <= off_s4;
			temp_s5 <= temp_s4;
		end
		if (adv_s6) begin
			q_s6    <= sum_adj[SUM_W-1:21];
			off_s6  <= off_s5;
			temp_s6 <= temp_s5;
		end
		if (adv_s7) begin
			diff_s7 <= DIFF_W'(q_s6) - DIFF_W'(off_s6);
			temp_s7 <= temp_s6;
		end
		if (adv_s8) begin
			pres_s8 <= diff_adj[PRES_W+12:13];
			temp_s8 <= temp_s7;
		end
	end

	assign out_valid         = valid_s8;
	assign temperature_centi = temp_s8;
	assign pressure_comp     = pres_s8;

endmodule

// ===== rtl/pressure_sensor_compensation_top.sv =====
// ---------------------------------------------------------------------------
// Pressure sensor first-order compensation
// A request accepted at the input is registered in each of the eight
// pipeline stages in turn before its result is valid.
// Throughput: one request per cycle unless a stalled result backs up the pipeline.
// A stalled result stops new requests only once every stage holds one.
// Reset clears all stage valid bits and the calibration words to zero.
// ---------------------------------------------------------------------------
module pressure_sensor_compensation_top
	import psc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	psc_smp_if.sink          smp,
	psc_res_if.source        res,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0] cfg_data
);

	psc_cal_t                 cal;
	logic                     mid_valid;
	logic                     mid_ready;
	logic [ADC_W-1:0]         mid_d1;
	logic signed [TEMP_W-1:0] mid_temp;
	logic signed [OFF_W-1:0]  mid_off;
	logic signed [SENS_W-1:0] mid_sens;

	psc_cal_regs u_cal_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cal       (cal)
	);

	psc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cal             (cal),
		.in_valid        (smp.valid),
		.in_ready        (smp.ready),
		.pressure_adc    (smp.pressure_adc),
		.temperature_adc (smp.temperature_adc),
		.out_valid       (mid_valid),
		.out_ready       (mid_ready),
		.d1              (mid_d1),
		.temp            (mid_temp),
		.off             (mid_off),
		.sens            (mid_sens)
	);

	psc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (mid_valid),
		.in_ready          (mid_ready),
		.d1                (mid_d1),
		.temp              (mid_temp),
		.off               (mid_off),
		.sens              (mid_sens),
		.out_valid         (res.valid),
		.out_ready         (res.ready),
		.temperature_centi (res.temperature_centi),
		.pressure_comp     (res.pressure_comp)
	);

endmodule
